[rtl/core/qrm_pkg.sv]
// Shared widths, types and constants for the quaternion to rotation matrix core.
`timescale 1ns / 1ps
package qrm_pkg;
  localparam int CompW  = 16;
  localparam int ProdW  = 32;
  localparam int NormW  = 33;
  localparam int NumW   = 34;
  localparam int DenW   = 34;
  localparam int RemW   = 48;
  localparam int QuoW   = 15;
  localparam int NumEnt = 9;
  localparam int PipeD  = 2 + QuoW + 1;
  localparam logic [QuoW-1:0] QOne = 15'd16384;

  typedef logic signed [CompW-1:0] comp_t;
  typedef logic signed [NumW-1:0]  num_t;
  typedef logic [NormW-1:0]        norm_t;

  typedef struct packed {
    logic en;
  } pipe_ctl_t;
endpackage

[rtl/core/qrm_forms.sv]
// Two register stages: component products, then norm squared and the nine quadratic forms.
`timescale 1ns / 1ps
module qrm_forms (
  input  logic              clk,
  input  qrm_pkg::pipe_ctl_t ctl,
  input  qrm_pkg::comp_t    w,
  input  qrm_pkg::comp_t    x,
  input  qrm_pkg::comp_t    y,
  input  qrm_pkg::comp_t    z,
  output qrm_pkg::norm_t    norm_o,
  output qrm_pkg::num_t     num_o [qrm_pkg::NumEnt]
);
  import qrm_pkg::*;

  logic signed [ProdW-1:0] ww_r, xx_r, yy_r, zz_r, xy_r, wz_r, xz_r, wy_r, yz_r, wx_r;
  norm_t norm_r;
  num_t  num_r [NumEnt];
  num_t  sww, sxx, syy, szz, sxy, swz, sxz, swy, syz, swx;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      ww_r <= w * w;
      xx_r <= x * x;
      yy_r <= y * y;
      zz_r <= z * z;
      xy_r <= x * y;
      wz_r <= w * z;
      xz_r <= x * z;
      wy_r <= w * y;
      yz_r <= y * z;
      wx_r <= w * x;
    end
  end

  always_comb begin
    sww = NumW'(ww_r);
    sxx = NumW'(xx_r);
    syy = NumW'(yy_r);
    szz = NumW'(zz_r);
    sxy = NumW'(xy_r);
    swz = NumW'(wz_r);
    sxz = NumW'(xz_r);
    swy = NumW'(wy_r);
    syz = NumW'(yz_r);
    swx = NumW'(wx_r);
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      norm_r   <= NormW'(sww + sxx + syy + szz);
      num_r[0] <= sww + sxx - syy - szz;
      num_r[1] <= (sxy - swz) <<< 1;
      num_r[2] <= (sxz + swy) <<< 1;
      num_r[3] <= (sxy + swz) <<< 1;
      num_r[4] <= sww - sxx + syy - szz;
      num_r[5] <= (syz - swx) <<< 1;
      num_r[6] <= (sxz - swy) <<< 1;
      num_r[7] <= (syz + swx) <<< 1;
      num_r[8] <= sww - sxx - syy + szz;
    end
  end

  assign norm_o = norm_r;
  assign num_o  = num_r;
endmodule

[rtl/core/qrm_divider.sv]
// Pipelined restoring divider, one quotient bit per stage: round(|num| * 16384 / norm).
`timescale 1ns / 1ps
module qrm_divider (
  input  logic               clk,
  input  qrm_pkg::pipe_ctl_t ctl,
  input  qrm_pkg::num_t      num,
  input  qrm_pkg::norm_t     norm,
  output logic [qrm_pkg::QuoW-1:0] quo_o,
  output logic               neg_o
);
  import qrm_pkg::*;

  logic [RemW-1:0] rem_r  [QuoW];
  logic [DenW-1:0] den_r  [QuoW];
  logic [QuoW-1:0] quo_r  [QuoW];
  logic            neg_r  [QuoW];
  logic [RemW-1:0] rem_nxt [QuoW];
  logic [QuoW-1:0] quo_nxt [QuoW];
  logic [NormW-1:0] mag;
  logic [RemW-1:0]  rem0;
  logic [DenW-1:0]  den0;

  // |num| never exceeds the norm, so the quotient fits in QuoW bits.
  always_comb begin
    mag  = num[NumW-1] ? NormW'(-num) : NormW'(num);
    rem0 = (RemW'(mag) << QuoW) + RemW'(norm);
    den0 = {norm, 1'b0};
  end

  for (genvar s = 0; s < QuoW; s++) begin : g_stage
    logic [RemW-1:0] rin;
    logic [DenW-1:0] din;
    logic [QuoW-1:0] qin;
    logic [RemW-1:0] dsh;
    always_comb begin
      rin = (s == 0) ? rem0 : rem_r[(s == 0) ? 0 : s - 1];
      din = (s == 0) ? den0 : den_r[(s == 0) ? 0 : s - 1];
      qin = (s == 0) ? '0   : quo_r[(s == 0) ? 0 : s - 1];
      dsh = RemW'(din) << (QuoW - 1 - s);
      if (rin >= dsh) begin
        rem_nxt[s] = rin - dsh;
        quo_nxt[s] = qin | (QuoW'(1) << (QuoW - 1 - s));
      end else begin
        rem_nxt[s] = rin;
        quo_nxt[s] = qin;
      end
    end
    always_ff @(posedge clk) begin
      if (ctl.en) begin
        rem_r[s] <= rem_nxt[s];
        den_r[s] <= din;
        quo_r[s] <= quo_nxt[s];
        neg_r[s] <= (s == 0) ? num[NumW-1] : neg_r[(s == 0) ? 0 : s - 1];
      end
    end
  end

  assign quo_o = quo_r[QuoW-1];
  assign neg_o = neg_r[QuoW-1];
endmodule

[rtl/core/quaternion_to_rotation_matrix_core.sv]
// Top level of the quaternion to rotation matrix core.
`timescale 1ns / 1ps
// Usage: one quaternion enters as a beat on the in_ channel, with w, x, y and z
// packed in in_tdata from the lowest bits up. For each input beat one result
// beat leaves on the out_ channel carrying the nine Q1.14 matrix entries in
// row order, and out_tuser flags a zero quaternion, in which case all entries
// are zero. The entries are normalized by dividing by the norm squared, rounded
// to nearest with ties away from zero.
// An accepted input beat passes two stages of products and sums, fifteen stages
// of the divider that produce one quotient bit each, and the output register
// before its result beat. Throughput is one beat per cycle unless stalled.
// The whole pipeline advances together; when the receiver holds out_tready low
// with a result waiting, every stage holds and in_tready drops, so nothing is
// lost or repeated. Reset clears all valid bits; the data path needs no reset.
module quaternion_to_rotation_matrix_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // comp_w, comp_x, comp_y, comp_z
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata,  // m00, m01, m02, m10, m11, m12, m20, m21, m22
  output logic         out_tuser   // zero_input
);
  import qrm_pkg::*;

  pipe_ctl_t ctl;
  norm_t     norm;
  num_t      num [NumEnt];
  logic [QuoW-1:0] quo [NumEnt];
  logic            neg [NumEnt];
  logic [PipeD-1:0] vld_r;
  logic [QuoW-1:0]  zero_r;
  logic [143:0]     data_r;
  logic             zero_out_r;
  logic [143:0]     data_nxt;

  assign ctl.en    = !vld_r[PipeD-1] || out_tready;
  assign in_tready = ctl.en;

  qrm_forms u_forms (
    .clk(clk), .ctl(ctl),
    .w(comp_t'(in_tdata[15:0])), .x(comp_t'(in_tdata[31:16])),
    .y(comp_t'(in_tdata[47:32])), .z(comp_t'(in_tdata[63:48])),
    .norm_o(norm), .num_o(num)
  );

  for (genvar e = 0; e < NumEnt; e++) begin : g_div
    qrm_divider u_div (
      .clk(clk), .ctl(ctl), .num(num[e]), .norm(norm),
      .quo_o(quo[e]), .neg_o(neg[e])
    );
  end

  always_comb begin
    logic [QuoW-1:0] q;
    logic [CompW-1:0] v;
    data_nxt = '0;
    for (int e = 0; e < NumEnt; e++) begin
      q = (quo[e] > QOne) ? QOne : quo[e];
      v = neg[e] ? CompW'(-{1'b0, q}) : CompW'({1'b0, q});
      data_nxt[e*CompW +: CompW] = zero_r[QuoW-1] ? '0 : v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.en) begin
      vld_r <= {vld_r[PipeD-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      zero_r     <= {zero_r[QuoW-2:0], (norm == '0)};
      data_r     <= data_nxt;
      zero_out_r <= zero_r[QuoW-1];
    end
  end

  assign out_tvalid = vld_r[PipeD-1];
  assign out_tdata  = data_r;
  assign out_tuser  = zero_out_r;

  a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("zero quaternion gave nonzero entries");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");

  a_diag_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[15:0]) <= 16'sd16384 &&
                    $signed(out_tdata[15:0]) >= -16'sd16384))
    else $error("m00 out of range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");
endmodule

[test/tb_quaternion_to_rotation_matrix_core.sv]
// Testbench for the quaternion to rotation matrix core: directed table and random beats.
`timescale 1ns / 1ps
module tb_quaternion_to_rotation_matrix_core;
  import qrm_pkg::*;

  typedef struct packed {
    logic [143:0] ents;
    logic         zflag;
  } matrix_t;

  typedef struct {
    logic [63:0] q;
    logic        known;
    matrix_t     m;
  } row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [63:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;
  logic         out_tuser;

  matrix_t matrix_q[$];
  int      err_cnt = 0;
  bit      calm = 1'b0;

  quaternion_to_rotation_matrix_core u_top (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always #1 clk = ~clk;

  function automatic logic [15:0] scale_ent(longint num, longint n);
    logic    neg;
    longint  mag, q;
    neg = num < 0;
    mag = neg ? -num : num;
    q = (2 * mag * 16384 + n) / (2 * n);
    if (q > 16384) q = 16384;
    if (neg) q = -q;
    return q[15:0];
  endfunction

  function automatic matrix_t rotation_of(logic [63:0] q);
    longint  w, x, y, z, ww, xx, yy, zz, n;
    longint  num[9];
    matrix_t r;
    w = longint'($signed(q[15:0]));
    x = longint'($signed(q[31:16]));
    y = longint'($signed(q[47:32]));
    z = longint'($signed(q[63:48]));
    ww = w * w; xx = x * x; yy = y * y; zz = z * z;
    n = ww + xx + yy + zz;
    r = '0;
    if (n == 0) begin
      r.zflag = 1'b1;
      return r;
    end
    num[0] = ww + xx - yy - zz;
    num[1] = 2 * (x * y - w * z);
    num[2] = 2 * (x * z + w * y);
    num[3] = 2 * (x * y + w * z);
    num[4] = ww - xx + yy - zz;
    num[5] = 2 * (y * z - w * x);
    num[6] = 2 * (x * z - w * y);
    num[7] = 2 * (y * z + w * x);
    num[8] = ww - xx - yy + zz;
    for (int i = 0; i < 9; i++) r.ents[16*i +: 16] = scale_ent(num[i], n);
    return r;
  endfunction

  function automatic logic [63:0] pack_q(int w, int x, int y, int z);
    logic [15:0] a, b, c, d;
    a = 16'(w); b = 16'(x); c = 16'(y); d = 16'(z);
    return {d, c, b, a};
  endfunction

  task automatic report(string what, logic [143:0] got, logic [143:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    err_cnt++;
  endtask

  task automatic send(logic [63:0] q);
    in_tvalid <= 1'b1;
    in_tdata  <= q;
    matrix_q.push_back(rotation_of(q));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic gap();
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] rand_q();
    case ($urandom_range(0, 4))
      0: return {$urandom, $urandom};
      1: return pack_q($urandom_range(0, 1) ? -32768 : 32767,
                       $signed(16'($urandom_range(0, 7)) - 16'sd4),
                       $signed(16'($urandom_range(0, 7)) - 16'sd4),
                       $signed(16'($urandom_range(0, 7)) - 16'sd4));
      2: return pack_q($signed(16'($urandom_range(0, 6)) - 16'sd3),
                       $signed(16'($urandom_range(0, 6)) - 16'sd3),
                       $signed(16'($urandom_range(0, 6)) - 16'sd3),
                       $signed(16'($urandom_range(0, 6)) - 16'sd3));
      default: return {$urandom, $urandom} & {4{16'h80ff}};
    endcase
  endfunction

  // Receiver side: random stalls and the check of each result beat.
  always @(posedge clk) begin
    matrix_t m;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (matrix_q.size() == 0) begin
          report("unexpected beat", out_tdata, '0);
        end else begin
          m = matrix_q.pop_front();
          for (int i = 0; i < 9; i++)
            if (out_tdata[16*i +: 16] !== m.ents[16*i +: 16])
              report($sformatf("entry %0d", i), out_tdata, m.ents);
          if (out_tuser !== m.zflag)
            report("zero flag", 144'(out_tuser), 144'(m.zflag));
        end
      end
      out_tready <= calm ? 1'b1 : ($urandom_range(0, 6) != 0);
    end
  end

  initial begin
    row_t rows[$];
    row_t r;
    matrix_t ident, zero_m, chk;
    ident = '0;
    ident.ents[15:0] = 16'd16384;
    ident.ents[16*4 +: 16] = 16'd16384;
    ident.ents[16*8 +: 16] = 16'd16384;
    zero_m = '0;
    zero_m.zflag = 1'b1;
    r.known = 1'b1; r.q = '0; r.m = zero_m; rows.push_back(r);
    r.q = pack_q(1, 0, 0, 0); r.m = ident; rows.push_back(r);
    r.q = pack_q(32767, 0, 0, 0); rows.push_back(r);
    r.q = pack_q(-32768, 0, 0, 0); rows.push_back(r);
    r.known = 1'b0;
    r.q = pack_q(0, -32768, 0, 0); rows.push_back(r);
    r.q = pack_q(0, 0, 32767, 0); rows.push_back(r);
    r.q = pack_q(0, 0, 0, -32768); rows.push_back(r);
    r.q = {4{16'h8000}}; rows.push_back(r);
    r.q = {4{16'h7fff}}; rows.push_back(r);
    r.q = pack_q(1, 1, 1, 1); rows.push_back(r);
    r.q = pack_q(1, -1, 0, 0); rows.push_back(r);
    r.q = pack_q(3, 0, 0, 0) ^ 64'h0; rows.push_back(r);
    r.q = pack_q(1, 2, 3, 4); rows.push_back(r);
    r.q = pack_q(0, 1, 1, 0); rows.push_back(r);
    r.q = pack_q(-32768, 32767, -32768, 32767); rows.push_back(r);
    r.q = 64'hffff_ffff_ffff_ffff; rows.push_back(r);
    r.q = pack_q(0, 0, 0, 1); rows.push_back(r);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) begin
      chk = rotation_of(rows[i].q);
      if (rows[i].known && rows[i].m != chk)
        report("table row", rows[i].m.ents, chk.ents);
      send(rows[i].q);
      gap();
    end
    for (int i = 0; i < 1830; i++) begin
      if (i == 900) begin
        in_tvalid <= 1'b0;
        while (matrix_q.size() != 0) @(posedge clk);
      end
      if (i == 1600) calm = 1'b1;
      send(rand_q());
      gap();
    end
    in_tvalid <= 1'b0;
    while (matrix_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end
endmodule

[quaternion_to_rotation_matrix_core.f]
rtl/core/qrm_pkg.sv
rtl/core/qrm_forms.sv
rtl/core/qrm_divider.sv
rtl/core/quaternion_to_rotation_matrix_core.sv
test/tb_quaternion_to_rotation_matrix_core.sv
